// ===== rtl/gkg_pkg.sv =====
// Package: shared types, operation codes and constant tables for the Gaussian kernel generator.
`timescale 1ns / 1ps
`default_nettype none
package gkg_pkg;
	localparam int NW   = 5;
	localparam int SW   = 16;
	localparam int CFW  = 16;
	localparam int SUMW = 17;

	localparam logic [4:0] OP_NONE  = 5'd0;
	localparam logic [4:0] OP_LOAD  = 5'd1;
	localparam logic [4:0] OP_ERR   = 5'd2;
	localparam logic [4:0] OP_TFILL = 5'd3;
	localparam logic [4:0] OP_SQS   = 5'd4;
	localparam logic [4:0] OP_S2CAP = 5'd5;
	localparam logic [4:0] OP_EDIV  = 5'd6;
	localparam logic [4:0] OP_ECAP  = 5'd7;
	localparam logic [4:0] OP_TMUL  = 5'd8;
	localparam logic [4:0] OP_KDIV  = 5'd9;
	localparam logic [4:0] OP_KCAP  = 5'd10;
	localparam logic [4:0] OP_DIFF  = 5'd11;
	localparam logic [4:0] OP_SQMUL = 5'd12;
	localparam logic [4:0] OP_SQCAP = 5'd13;
	localparam logic [4:0] OP_WST   = 5'd14;
	localparam logic [4:0] OP_TOT   = 5'd15;
	localparam logic [4:0] OP_NDIV  = 5'd16;
	localparam logic [4:0] OP_NCAP  = 5'd17;
	localparam logic [4:0] OP_EMIT  = 5'd18;
	localparam logic [4:0] OP_KMUL  = 5'd19;

	typedef struct packed {
		logic [4:0] op;
		logic [3:0] j;
		logic [2:0] k;
		logic [4:0] i;
	} gkg_cmd_t;

	typedef struct packed {
		logic       err;
		logic       tbl;
		logic [3:0] h;
		logic [4:0] n;
		logic       zero;
		logic       div_done;
	} gkg_stat_t;

	typedef logic [23:0] s16_tab_t [32];

	function automatic s16_tab_t build_s16();
		s16_tab_t t;
		for (int n = 0; n < 32; n++) begin
			t[n] = 24'(((15 * n + 35) * 65536 + 50) / 100);
		end
		return t;
	endfunction

	// derived sigma in Q8.16 for sigma zero
	localparam s16_tab_t S16_DEF = build_s16();

	// binomial half tables, Q0.16
	localparam logic [15:0] BINOM [5][5] = '{
		'{16'd65535, 16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd16384, 16'd32768, 16'd0,     16'd0,     16'd0},
		'{16'd4096,  16'd16384, 16'd24576, 16'd0,     16'd0},
		'{16'd2048,  16'd7168,  16'd14336, 16'd18432, 16'd0},
		'{16'd1024,  16'd3328,  16'd7680,  16'd13056, 16'd15360}
	};

	// ceil(2^35 / k): exact floor division by k for 32-bit dividends
	localparam logic [35:0] KRECIP [8] = '{
		36'd0,          36'd34359738368, 36'd17179869184, 36'd11453246123,
		36'd8589934592, 36'd6871947674,  36'd5726623062,  36'd4908534053
	};

	localparam logic [22:0] EXP_LIMIT = 23'd2621440;
	localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
endpackage
`default_nettype wire

// ===== rtl/gkg_div.sv =====
// Shared bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gkg_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [47:0] rem_init,
	input  wire logic [31:0] low,
	input  wire logic [5:0]  cnt,
	input  wire logic [47:0] den,
	output logic      [31:0] quo,
	output logic             done
);
	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [47:0] rem_q, den_q;
	logic [31:0] low_q, quo_q;
	logic [48:0] trial, diff;
	logic        ge;

	assign trial = {rem_q, low_q[31]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= cnt;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= rem_init;
			low_q <= low;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[47:0] : trial[47:0];
			low_q <= {low_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/gkg_datapath.sv =====
// Datapath: shared multiplier, exp series, weight and coefficient stores, result registers.
`timescale 1ns / 1ps
`default_nettype none
module gkg_datapath import gkg_pkg::*; #(
	parameter int MAX_TAPS = 31
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire gkg_cmd_t        cmd,
	input  wire logic [NW-1:0]   kernel_size,
	input  wire logic [SW-1:0]   sigma,
	output gkg_stat_t            stat,
	output logic                 strobe,
	output logic [CFW-1:0]       coefficient,
	output logic [NW-1:0]        tap_index,
	output logic                 last,
	output logic                 status,
	output logic [SUMW-1:0]      coefficient_sum
);
	localparam int MAXN  = (MAX_TAPS < 31) ? MAX_TAPS : 31;
	localparam int HMAX  = (MAXN - 1) / 2;
	localparam int DEPTH = HMAX + 1;
	localparam int AW    = (HMAX > 0) ? $clog2(HMAX + 1) : 1;

	logic [4:0]  n_q;
	logic [15:0] sg_q;
	logic [47:0] s2_q;
	logic [63:0] prod_q;
	logic [28:0] r_q;
	logic [31:0] t_q, pos_q, neg_q;
	logic [31:0] kx_q;
	logic [66:0] kprod_q;
	logic        zero_q, ovf_q;
	logic [36:0] total_q;
	logic [31:0] w_q [DEPTH];
	logic [15:0] c_q [DEPTH];
	logic [16:0] run_q;
	logic        strobe_q;

	logic [3:0]  h;
	logic        err, tbl;
	logic [23:0] s16;
	logic [AW-1:0] jx;
	logic [4:0]  x;
	logic [9:0]  xsq;
	logic [55:0] num_e;
	logic [63:0] rnd;
	logic [31:0] kx, kq;
	logic [31:0] wsel, wv;
	logic [47:0] num_n;
	logic        div_go, div_done;
	logic [47:0] d_rem, d_den;
	logic [31:0] d_low, div_q;
	logic [5:0]  d_cnt;
	logic [4:0]  nm1, hh, cidx;
	logic [15:0] coef;
	logic [16:0] run_n;

	assign h    = 4'((n_q - 5'd1) >> 1);
	assign err  = (n_q == 5'd0) || ({27'd0, n_q} > MAX_TAPS);
	assign tbl  = (sg_q == 16'd0) && n_q[0] && (n_q <= 5'd9);
	assign s16  = (sg_q != 16'd0) ? {sg_q, 8'd0} : S16_DEF[n_q];
	assign jx   = cmd.j[AW-1:0];
	assign x    = n_q - 5'd1 - {cmd.j, 1'b0};
	assign xsq  = 10'({5'd0, x} * {5'd0, x});
	assign num_e = {1'b0, xsq, 45'd0} + {9'd0, s2_q[47:1]};
	assign rnd  = prod_q + (64'd1 << 30);
	assign kx   = rnd[62:31] + {30'd0, cmd.k[2:1]};
	assign kq   = kprod_q[66:35];
	assign wsel = ({1'b0, cmd.j} == hh) ? ONE_Q31 : w_q[jx];
	assign wv   = zero_q ? 32'd0 : t_q;
	assign num_n = {wsel, 16'd0} + {12'd0, total_q[36:1]};

	assign nm1  = n_q - 5'd1;
	assign hh   = {1'b0, h};
	always_comb begin
		if (cmd.i < hh)
			cidx = cmd.i;
		else if (cmd.i > nm1 - hh)
			cidx = nm1 - cmd.i;
		else
			cidx = hh;
	end
	assign coef  = c_q[cidx[AW-1:0]];
	assign run_n = ((cmd.i == 5'd0) ? 17'd0 : run_q) + {1'b0, coef};

	always_comb begin
		div_go = 1'b0;
		d_rem  = '0;
		d_low  = '0;
		d_cnt  = '0;
		d_den  = '0;
		unique case (cmd.op)
			OP_EDIV: begin
				div_go = 1'b1;
				d_rem  = {15'd0, num_e[55:23]};
				d_low  = {num_e[22:0], 9'd0};
				d_cnt  = 6'd23;
				d_den  = s2_q;
			end
			OP_NDIV: begin
				div_go = 1'b1;
				d_rem  = {17'd0, num_n[47:17]};
				d_low  = {num_n[16:0], 15'd0};
				d_cnt  = 6'd17;
				d_den  = {11'd0, total_q};
			end
			default: begin
			end
		endcase
	end

	gkg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.rem_init (d_rem),
		.low      (d_low),
		.cnt      (d_cnt),
		.den      (d_den),
		.quo      (div_q),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.op == OP_EMIT) || (cmd.op == OP_ERR);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				n_q  <= kernel_size;
				sg_q <= sigma;
			end
			OP_ERR: begin
				coefficient     <= '0;
				tap_index       <= '0;
				last            <= 1'b1;
				status          <= 1'b1;
				coefficient_sum <= '0;
			end
			OP_TFILL: c_q[jx] <= BINOM[h[2:0]][cmd.j[2:0]];
			OP_SQS:   prod_q <= 64'(s16) * 64'(s16);
			OP_S2CAP: begin
				s2_q    <= prod_q[47:0];
				total_q <= '0;
			end
			OP_EDIV:  ovf_q <= {15'd0, num_e[55:23]} >= s2_q;
			OP_ECAP: begin
				zero_q <= ovf_q || (div_q[22:0] >= EXP_LIMIT);
				r_q    <= {div_q[21:0], 7'd0};
				t_q    <= ONE_Q31;
				pos_q  <= ONE_Q31;
				neg_q  <= '0;
			end
			OP_TMUL:  prod_q <= 64'(t_q) * 64'(r_q);
			OP_KDIV:  kx_q <= kx;
			OP_KMUL:  kprod_q <= 67'(kx_q) * 67'(KRECIP[cmd.k]);
			OP_KCAP: begin
				t_q <= kq;
				if (cmd.k[0])
					neg_q <= neg_q + kq;
				else
					pos_q <= pos_q + kq;
			end
			OP_DIFF:  t_q <= pos_q - neg_q;
			OP_SQMUL: prod_q <= 64'(t_q) * 64'(t_q);
			OP_SQCAP: t_q <= rnd[62:31];
			OP_WST: begin
				w_q[jx] <= wv;
				total_q <= total_q + {4'd0, wv, 1'b0};
			end
			OP_TOT:   total_q <= total_q + (n_q[0] ? 37'h0_8000_0000 : 37'h1_0000_0000);
			OP_NCAP:  c_q[jx] <= (div_q[31:16] != 16'd0) ? 16'hFFFF : div_q[15:0];
			OP_EMIT: begin
				coefficient     <= coef;
				tap_index       <= cmd.i;
				last            <= (cmd.i == nm1);
				status          <= 1'b0;
				coefficient_sum <= run_n;
				run_q           <= run_n;
			end
			default: begin
			end
		endcase
	end

	assign strobe        = strobe_q;
	assign stat.err      = err;
	assign stat.tbl      = tbl;
	assign stat.h        = h;
	assign stat.n        = n_q;
	assign stat.zero     = zero_q;
	assign stat.div_done = div_done;
endmodule
`default_nettype wire

// ===== rtl/gkg_ctrl.sv =====
// Controller state machine: sequences weights, normalization and tap output.
`timescale 1ns / 1ps
`default_nettype none
module gkg_ctrl import gkg_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire gkg_stat_t stat,
	output gkg_cmd_t       cmd,
	output logic           busy
);
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_CHECK = 5'd1;
	localparam logic [4:0] ST_TFILL = 5'd2;
	localparam logic [4:0] ST_S2    = 5'd3;
	localparam logic [4:0] ST_EDIV  = 5'd4;
	localparam logic [4:0] ST_EWAIT = 5'd5;
	localparam logic [4:0] ST_SER   = 5'd6;
	localparam logic [4:0] ST_KDIV  = 5'd7;
	localparam logic [4:0] ST_KWAIT = 5'd8;
	localparam logic [4:0] ST_DIFF  = 5'd9;
	localparam logic [4:0] ST_SQ    = 5'd10;
	localparam logic [4:0] ST_SQC   = 5'd11;
	localparam logic [4:0] ST_WST   = 5'd12;
	localparam logic [4:0] ST_TOT   = 5'd13;
	localparam logic [4:0] ST_NDIV  = 5'd14;
	localparam logic [4:0] ST_NWAIT = 5'd15;
	localparam logic [4:0] ST_EMIT  = 5'd16;
	localparam logic [4:0] ST_KCAP  = 5'd17;

	logic [4:0] state_q, state_d;
	logic [3:0] j_q, j_d;
	logic [2:0] k_q, k_d;
	logic [4:0] i_q, i_d;
	logic [4:0] op;

	always_comb begin
		state_d = state_q;
		j_d     = j_q;
		k_d     = k_q;
		i_d     = i_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					op      = OP_LOAD;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				j_d = 4'd0;
				i_d = 5'd0;
				if (stat.err) begin
					op      = OP_ERR;
					state_d = ST_IDLE;
				end else if (stat.tbl) begin
					state_d = ST_TFILL;
				end else begin
					op      = OP_SQS;
					state_d = ST_S2;
				end
			end
			ST_TFILL: begin
				op = OP_TFILL;
				if (j_q == stat.h)
					state_d = ST_EMIT;
				else
					j_d = j_q + 4'd1;
			end
			ST_S2: begin
				op      = OP_S2CAP;
				state_d = (stat.h == 4'd0) ? ST_TOT : ST_EDIV;
			end
			ST_EDIV: begin
				op      = OP_EDIV;
				state_d = ST_EWAIT;
			end
			ST_EWAIT: begin
				if (stat.div_done) begin
					op      = OP_ECAP;
					k_d     = 3'd1;
					state_d = ST_SER;
				end
			end
			ST_SER: begin
				if (stat.zero) begin
					state_d = ST_WST;
				end else begin
					op      = OP_TMUL;
					state_d = ST_KDIV;
				end
			end
			ST_KDIV: begin
				op      = OP_KDIV;
				state_d = ST_KWAIT;
			end
			ST_KWAIT: begin
				op      = OP_KMUL;
				state_d = ST_KCAP;
			end
			ST_KCAP: begin
				op = OP_KCAP;
				if (k_q == 3'd7) begin
					state_d = ST_DIFF;
				end else begin
					k_d     = k_q + 3'd1;
					state_d = ST_SER;
				end
			end
			ST_DIFF: begin
				op      = OP_DIFF;
				k_d     = 3'd0;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				op      = OP_SQMUL;
				state_d = ST_SQC;
			end
			ST_SQC: begin
				op = OP_SQCAP;
				if (k_q == 3'd7) begin
					state_d = ST_WST;
				end else begin
					k_d     = k_q + 3'd1;
					state_d = ST_SQ;
				end
			end
			ST_WST: begin
				op = OP_WST;
				if (j_q == stat.h - 4'd1) begin
					state_d = ST_TOT;
				end else begin
					j_d     = j_q + 4'd1;
					state_d = ST_EDIV;
				end
			end
			ST_TOT: begin
				op      = OP_TOT;
				j_d     = 4'd0;
				state_d = ST_NDIV;
			end
			ST_NDIV: begin
				op      = OP_NDIV;
				state_d = ST_NWAIT;
			end
			ST_NWAIT: begin
				if (stat.div_done) begin
					op = OP_NCAP;
					if (j_q == stat.h) begin
						state_d = ST_EMIT;
					end else begin
						j_d     = j_q + 4'd1;
						state_d = ST_NDIV;
					end
				end
			end
			ST_EMIT: begin
				op = OP_EMIT;
				if (i_q == stat.n - 5'd1)
					state_d = ST_IDLE;
				else
					i_d = i_q + 5'd1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			k_q     <= k_d;
			i_q     <= i_d;
		end
	end

	assign cmd.op = op;
	assign cmd.j  = j_q;
	assign cmd.k  = k_q;
	assign cmd.i  = i_q;
	assign busy   = (state_q != ST_IDLE);
endmodule
`default_nettype wire

// ===== rtl/gaussian_kernel_generator.sv =====
// Top level: Gaussian kernel coefficient generator.
// A request (kernel_size, sigma) is taken when start is high and busy is low. The block then
// emits one item per tap, in tap order, each on the output ports for one cycle with strobe
// high; the receiver cannot stall, so it must take every strobed item. Sigma zero with sizes
// 1, 3, 5, 7 or 9 uses binomial tables. Any other request computes, per outer tap, one
// 23-step division, seven series terms of a multiply and a reciprocal multiply each, and
// eight squarings (series and squarings are skipped when the weight underflows), then one
// 17-step division per distinct coefficient on a shared bit-serial divider. An invalid
// size gives one item with status set. A new request is taken once busy falls.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_kernel_generator import gkg_pkg::*; #(
	parameter int MAX_TAPS = 31
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic [NW-1:0]   kernel_size,
	input  wire logic [SW-1:0]   sigma,
	output logic                 strobe,
	output logic [CFW-1:0]       coefficient,
	output logic [NW-1:0]        tap_index,
	output logic                 last,
	output logic                 status,
	output logic [SUMW-1:0]      coefficient_sum
);
	gkg_cmd_t  cmd;
	gkg_stat_t stat;

	gkg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	gkg_datapath #(
		.MAX_TAPS (MAX_TAPS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.kernel_size     (kernel_size),
		.sigma           (sigma),
		.stat            (stat),
		.strobe          (strobe),
		.coefficient     (coefficient),
		.tap_index       (tap_index),
		.last            (last),
		.status          (status),
		.coefficient_sum (coefficient_sum)
	);
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the Gaussian kernel generator: random and directed requests checked per tap.
`timescale 1ns / 1ps
module tb;
	import gkg_pkg::*;

	typedef struct {
		logic [NW-1:0] size;
		logic [SW-1:0] sg;
	} request_t;

	typedef struct {
		logic [CFW-1:0]  coef;
		logic [NW-1:0]   idx;
		logic            lst;
		logic            st;
		logic [SUMW-1:0] csum;
	} tap_t;

	localparam int MAX_TAPS_TB = 31;
	localparam int IDLE_LIMIT  = 40000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [NW-1:0] kernel_size = '0;
	logic [SW-1:0] sigma = '0;
	logic busy, strobe, last, status;
	logic [CFW-1:0] coefficient;
	logic [NW-1:0] tap_index;
	logic [SUMW-1:0] coefficient_sum;
	logic busy_at_edge = 1'b1;

	request_t pending_reqs[$];
	tap_t expected_taps[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int gap = 0;
	bit stim_done = 1'b0;

	gaussian_kernel_generator #(.MAX_TAPS(MAX_TAPS_TB)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kernel_size(kernel_size), .sigma(sigma), .strobe(strobe),
		.coefficient(coefficient), .tap_index(tap_index), .last(last),
		.status(status), .coefficient_sum(coefficient_sum)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] exp_weight(logic [63:0] xsq, logic [63:0] s2);
		logic [63:0] e, r, t, pos, neg;
		e = ((xsq << 45) + s2 / 2) / s2;
		if (e >= (64'd40 << 16))
			return 64'd0;
		r = e << 7;
		t = 64'h8000_0000;
		pos = t;
		neg = 0;
		for (int k = 1; k <= 7; k++) begin
			t = (t * r + (64'd1 << 30)) >> 31;
			t = (t + k / 2) / k;
			if (k % 2)
				neg += t;
			else
				pos += t;
		end
		t = pos - neg;
		for (int k = 0; k < 8; k++)
			t = (t * t + (64'd1 << 30)) >> 31;
		return t;
	endfunction

	function automatic logic [63:0] norm_q16(logic [63:0] w, logic [63:0] total);
		logic [63:0] c;
		c = (w * 65536 + total / 2) / total;
		return (c > 65535) ? 64'd65535 : c;
	endfunction

	task automatic predict_kernel(request_t rq);
		logic [63:0] outer[32];
		logic [63:0] w[32];
		logic [63:0] centre, s16, s2, total, c, run;
		int n, h;
		tap_t tp;
		n = int'(rq.size);
		run = 0;
		if (n == 0 || n > MAX_TAPS_TB) begin
			tp = '{coef: '0, idx: '0, lst: 1'b1, st: 1'b1, csum: '0};
			expected_taps.push_back(tp);
			return;
		end
		h = (n - 1) / 2;
		if (rq.sg == 0 && n % 2 == 1 && n <= 9) begin
			for (int j = 0; j < h; j++)
				outer[j] = 64'(BINOM[h][j]);
			centre = 64'(BINOM[h][h]);
		end else begin
			s16 = rq.sg ? (64'(rq.sg) << 8) : ((64'(15 * n + 35) * 65536 + 50) / 100);
			s2 = s16 * s16;
			total = 0;
			for (int j = 0; j < h; j++) begin
				w[j] = exp_weight(64'((n - 1 - 2 * j) * (n - 1 - 2 * j)), s2);
				total += w[j];
			end
			total = 2 * total + ((n % 2) ? 64'h8000_0000 : 64'h1_0000_0000);
			for (int j = 0; j < h; j++)
				outer[j] = norm_q16(w[j], total);
			centre = norm_q16(64'h8000_0000, total);
		end
		for (int i = 0; i < n; i++) begin
			if (i < h)
				c = outer[i];
			else if (i > n - 1 - h)
				c = outer[n - 1 - i];
			else
				c = centre;
			run += c;
			tp = '{coef: c[15:0], idx: i[4:0], lst: (i == n - 1), st: 1'b0,
				csum: run[16:0]};
			expected_taps.push_back(tp);
		end
	endtask

	function automatic int rand_gap();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 60)) :
			int'($urandom_range(0, 3));
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy_at_edge) begin
				start <= 1'b0;
				gap = rand_gap();
			end else if (!start) begin
				if (gap > 0)
					gap--;
				else if (pending_reqs.size() > 0) begin
					request_t rq;
					rq = pending_reqs.pop_front();
					kernel_size <= rq.size;
					sigma <= rq.sg;
					start <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		busy_at_edge <= busy;
		if (arst_n) begin
			idle_cycles++;
			if (start && !busy) begin
				predict_kernel('{size: kernel_size, sg: sigma});
				idle_cycles = 0;
			end
			if (strobe) begin
				idle_cycles = 0;
				if (expected_taps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected tap idx=%0d coef=%0d", tap_index, coefficient);
				end else begin
					tap_t ex;
					ex = expected_taps.pop_front();
					if (coefficient !== ex.coef || tap_index !== ex.idx || last !== ex.lst ||
						status !== ex.st || coefficient_sum !== ex.csum) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"tap mismatch: exp c=%0d i=%0d l=%0d s=%0d sum=%0d,",
								" got c=%0d i=%0d l=%0d s=%0d sum=%0d"},
								ex.coef, ex.idx, ex.lst, ex.st, ex.csum, coefficient,
								tap_index, last, status, coefficient_sum);
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic request_t rand_req();
		request_t rq;
		int sel;
		sel = int'($urandom_range(0, 9));
		if (sel < 6)
			rq.size = 5'($urandom_range(1, 9));
		else if (sel < 9)
			rq.size = 5'($urandom_range(0, 31));
		else
			rq.size = 5'd31;
		case ($urandom_range(0, 5))
			0: rq.sg = 16'd0;
			1: rq.sg = 16'($urandom_range(1, 64));
			2: rq.sg = 16'($urandom_range(128, 1024));
			3: rq.sg = 16'($urandom());
			default: rq.sg = 16'($urandom_range(64, 4096));
		endcase
		return rq;
	endfunction

	initial begin
		for (int n = 0; n < 10; n++)
			pending_reqs.push_back('{size: 5'(n), sg: 16'd0});
		pending_reqs.push_back('{size: 5'd31, sg: 16'd0});
		pending_reqs.push_back('{size: 5'd31, sg: 16'hFFFF});
		pending_reqs.push_back('{size: 5'd30, sg: 16'd1});
		pending_reqs.push_back('{size: 5'd1, sg: 16'd300});
		pending_reqs.push_back('{size: 5'd0, sg: 16'hFFFF});
		pending_reqs.push_back('{size: 5'd4, sg: 16'h0100});
		pending_reqs.push_back('{size: 5'd7, sg: 16'h5555});
		pending_reqs.push_back('{size: 5'd16, sg: 16'hAAAA});
		pending_reqs.push_back('{size: 5'd11, sg: 16'd0});
		pending_reqs.push_back('{size: 5'd2, sg: 16'd0});
		for (int k = 0; k < 230; k++)
			pending_reqs.push_back(rand_req());
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && !start);
		wait (expected_taps.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_taps.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
